@@ rtl/firewall_rule_first_match_assert.svh @@
// ----------------------------------------------------------------------------
// firewall_rule_first_match assertion macros
// Concurrent assertion wrappers clocked on clock; FRFM_ASSERT is gated by reset.
// ----------------------------------------------------------------------------
`ifndef FIREWALL_RULE_FIRST_MATCH_ASSERT_SVH
`define FIREWALL_RULE_FIRST_MATCH_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked outside reset
`define FRFM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// property checked on every edge, reset included
`define FRFM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FRFM_ASSERT(lbl, prop, msg)
`define FRFM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/frfm_pkg.sv @@
// ----------------------------------------------------------------------------
// frfm_pkg
// Shared types, encodings and helper functions of the rule table block.
// ----------------------------------------------------------------------------
package frfm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_W     = 6;
   localparam int CNT_W       = 7;
   localparam int PORT_W      = 10;

   localparam logic [31:0] FULL_MASK = 32'hFFFF_FFFF;

   localparam logic       REQ_WRITE = 1'b0;
   localparam logic       REQ_MATCH = 1'b1;

   localparam logic [1:0] DIR_ANY = 2'd3;
   localparam logic [1:0] ACK_ANY = 2'd3;

   localparam logic [7:0] PROTO_ICMP  = 8'd1;
   localparam logic [7:0] PROTO_TCP   = 8'd6;
   localparam logic [7:0] PROTO_UDP   = 8'd17;
   localparam logic [7:0] PROTO_OTHER = 8'd255;
   localparam logic [7:0] PROTO_ANY   = 8'd143;

   localparam logic [15:0] PORT_HIGH = 16'd1023;
   localparam logic [5:0]  PREFIX_MAX = 6'd32;

   typedef enum logic [1:0] {
      ST_STORED   = 2'd0,
      ST_REJECTED = 2'd1,
      ST_MATCH    = 2'd2,
      ST_NO_MATCH = 2'd3
   } status_type;

   // stored rule: prefix lengths kept, masks rebuilt on read
   typedef struct packed {
      logic [1:0]        direction;
      logic [7:0]        protocol;
      logic [31:0]       src_ip;
      logic [31:0]       dst_ip;
      logic [5:0]        src_prefix_len;
      logic [5:0]        dst_prefix_len;
      logic [PORT_W-1:0] sport;
      logic [PORT_W-1:0] dport;
      logic [1:0]        ack;
      logic              action;
   } rule_entry_type;

   typedef struct packed {
      logic [1:0]  direction;
      logic [7:0]  protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  ack;
   } packet_type;

   typedef struct packed {
      logic                    wr_en;
      logic [INDEX_W-1:0]      wr_addr;
      logic                    rd_en;
      logic [INDEX_W-1:0]      rd_addr;
   } ram_ctrl_type;

   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len == 6'd0) begin
         m = 32'd0;
      end else begin
         m = FULL_MASK << (PREFIX_MAX - len);
      end
      return m;
   endfunction

   function automatic logic port_hit(input logic [PORT_W-1:0] rp, input logic [15:0] pp);
      logic [15:0] rp_w;
      rp_w = {{(16-PORT_W){1'b0}}, rp};
      return (rp_w == 16'd0) || ((rp_w == PORT_HIGH) && (pp >= PORT_HIGH)) || (rp_w == pp);
   endfunction

endpackage

@@ rtl/firewall_rule_first_match.sv @@
// ----------------------------------------------------------------------------
// firewall_rule_first_match
// First-match packet filter over a 64-entry rule memory.
// ----------------------------------------------------------------------------
// One request at a time. A rule write is checked and stored in the cycle it is
// accepted, and its response goes through the hold state to the output
// register. A match request reads the rule memory one entry per cycle,
// starting at entry 0, and stops at the first hit or after min(rule_count, 64)
// entries; the rule memory has a single read port. A finished response sits
// in an output register, so the next request is taken while it waits. The
// memory is not cleared after reset: scanning an entry never written gives an
// undefined result.
module firewall_rule_first_match (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [5:0]  req_rule_index,
   input  logic [1:0]  req_direction,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [5:0]  req_src_prefix_len,
   input  logic [5:0]  req_dst_prefix_len,
   input  logic [15:0] req_sport,
   input  logic [15:0] req_dport,
   input  logic [1:0]  req_ack,
   input  logic        req_rule_action,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_rule_number,
   output logic        rsp_verdict,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import frfm_pkg::*;

   `include "firewall_rule_first_match_assert.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_HOLD
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   rule_count_ff;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [INDEX_W-1:0] last_ff, last_in;
   packet_type         pkt_ff, pkt_in;
   status_type         res_status_ff, res_status_in;
   logic [CNT_W-1:0]   res_number_ff, res_number_in;
   logic               res_verdict_ff, res_verdict_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   rsp_number_ff, rsp_number_in;
   logic               rsp_verdict_ff, rsp_verdict_in;

   logic               req_accept;
   logic               out_free;
   logic               rule_ok;
   logic               hit;
   logic               at_last;
   logic [CNT_W-1:0]   scan_len;
   rule_entry_type     wr_entry;
   rule_entry_type     rd_entry;
   ram_ctrl_type       ram_ctrl;

   frfm_rule_check u_check (
      .rule_index     (req_rule_index),
      .direction      (req_direction),
      .protocol       (req_protocol),
      .src_ip         (req_src_ip),
      .dst_ip         (req_dst_ip),
      .src_prefix_len (req_src_prefix_len),
      .dst_prefix_len (req_dst_prefix_len),
      .sport          (req_sport),
      .dport          (req_dport),
      .ack            (req_ack),
      .rule_action    (req_rule_action),
      .rule_ok        (rule_ok),
      .entry          (wr_entry)
   );

   frfm_rule_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   frfm_rule_match u_match (
      .entry (rd_entry),
      .pkt   (pkt_ff),
      .hit   (hit)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign at_last    = (idx_ff == last_ff);
   assign scan_len   = (rule_count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                            : rule_count_ff;

   always_comb begin
      ram_ctrl.wr_en   = req_accept && (req_type == REQ_WRITE) && rule_ok;
      ram_ctrl.wr_addr = req_rule_index;
      ram_ctrl.rd_en   = 1'b0;
      ram_ctrl.rd_addr = idx_ff + INDEX_W'(1);
      if (state_ff == S_IDLE) begin
         ram_ctrl.rd_en   = req_accept && (req_type == REQ_MATCH);
         ram_ctrl.rd_addr = '0;
      end else if (state_ff == S_SCAN) begin
         ram_ctrl.rd_en   = !hit && !at_last;
      end
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      last_in        = last_ff;
      pkt_in         = pkt_ff;
      res_status_in  = res_status_ff;
      res_number_in  = res_number_ff;
      res_verdict_in = res_verdict_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_number_in  = rsp_number_ff;
      rsp_verdict_in = rsp_verdict_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_number_in  = '0;
               res_verdict_in = 1'b0;
               idx_in         = '0;
               last_in        = INDEX_W'(scan_len - CNT_W'(1));
               pkt_in.direction = req_direction;
               pkt_in.protocol  = req_protocol;
               pkt_in.src_ip    = req_src_ip;
               pkt_in.dst_ip    = req_dst_ip;
               pkt_in.sport     = req_sport;
               pkt_in.dport     = req_dport;
               pkt_in.ack       = req_ack;
               if (req_type == REQ_WRITE) begin
                  res_status_in = rule_ok ? ST_STORED : ST_REJECTED;
                  state_in      = S_HOLD;
               end else if (scan_len == '0) begin
                  res_status_in = ST_NO_MATCH;
                  state_in      = S_HOLD;
               end else begin
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_status_in  = ST_MATCH;
               res_number_in  = CNT_W'(idx_ff) + CNT_W'(1);
               res_verdict_in = rd_entry.action;
               state_in       = S_HOLD;
            end else if (at_last) begin
               res_status_in  = ST_NO_MATCH;
               state_in       = S_HOLD;
            end else begin
               idx_in         = idx_ff + INDEX_W'(1);
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_number_in  = res_number_ff;
               rsp_verdict_in = res_verdict_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         rule_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rule_count_ff <= csr_wr_data;
         end
      end
      idx_ff         <= idx_in;
      last_ff        <= last_in;
      pkt_ff         <= pkt_in;
      res_status_ff  <= res_status_in;
      res_number_ff  <= res_number_in;
      res_verdict_ff <= res_verdict_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_number_ff  <= rsp_number_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_rule_number = rsp_number_ff;
   assign rsp_verdict     = rsp_verdict_ff;

   `FRFM_ASSERT(a_write_to_hold, (req_accept && (req_type == REQ_WRITE)) |=> (state_ff == S_HOLD), "rule write did not go straight to response")
   `FRFM_ASSERT(a_scan_bound, (state_ff == S_SCAN) |-> (idx_ff <= last_ff), "scan index ran past the active rule count")
   `FRFM_ASSERT(a_hold_loads, ((state_ff == S_HOLD) && out_free) |=> (rsp_valid_ff && (state_ff == S_IDLE)), "finished response not loaded into output register")
   `FRFM_ASSERT(a_number_status, rsp_valid_ff |-> ((rsp_status_ff == ST_MATCH) == (rsp_number_ff != '0)), "rule number disagrees with status")
   `FRFM_ASSERT_ALWAYS(a_reset_idle, reset |=> ((state_ff == S_IDLE) && !rsp_valid_ff), "block not idle after reset")

endmodule

@@ rtl/frfm_rule_ram.sv @@
// ----------------------------------------------------------------------------
// frfm_rule_ram
// Rule storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frfm_rule_ram (
   input  logic                    clock,
   input  frfm_pkg::ram_ctrl_type  ctrl,
   input  frfm_pkg::rule_entry_type wr_data,
   output frfm_pkg::rule_entry_type rd_data
);
   import frfm_pkg::*;

   rule_entry_type mem [TABLE_DEPTH];
   rule_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/frfm_rule_check.sv @@
// ----------------------------------------------------------------------------
// frfm_rule_check
// Validates the encodings of a rule write and packs it into a table entry.
// ----------------------------------------------------------------------------
module frfm_rule_check (
   input  logic [5:0]               rule_index,
   input  logic [1:0]               direction,
   input  logic [7:0]               protocol,
   input  logic [31:0]              src_ip,
   input  logic [31:0]              dst_ip,
   input  logic [5:0]               src_prefix_len,
   input  logic [5:0]               dst_prefix_len,
   input  logic [15:0]              sport,
   input  logic [15:0]              dport,
   input  logic [1:0]               ack,
   input  logic                     rule_action,
   output logic                     rule_ok,
   output frfm_pkg::rule_entry_type entry
);
   import frfm_pkg::*;

   logic index_ok;
   logic proto_ok;

   assign index_ok = {1'b0, rule_index} < CNT_W'(TABLE_DEPTH);
   assign proto_ok = (protocol == PROTO_ICMP) || (protocol == PROTO_TCP) ||
                     (protocol == PROTO_UDP)  || (protocol == PROTO_OTHER) ||
                     (protocol == PROTO_ANY);

   assign rule_ok = index_ok && proto_ok &&
                    (direction != 2'd0) && (ack != 2'd0) &&
                    (src_prefix_len <= PREFIX_MAX) && (dst_prefix_len <= PREFIX_MAX) &&
                    (sport <= PORT_HIGH) && (dport <= PORT_HIGH);

   // ports fit in PORT_W bits once checked
   always_comb begin
      entry.direction      = direction;
      entry.protocol       = protocol;
      entry.src_ip         = src_ip;
      entry.dst_ip         = dst_ip;
      entry.src_prefix_len = src_prefix_len;
      entry.dst_prefix_len = dst_prefix_len;
      entry.sport          = sport[PORT_W-1:0];
      entry.dport          = dport[PORT_W-1:0];
      entry.ack            = ack;
      entry.action         = rule_action;
   end

endmodule

@@ rtl/frfm_rule_match.sv @@
// ----------------------------------------------------------------------------
// frfm_rule_match
// Compares one stored rule against the held packet header.
// ----------------------------------------------------------------------------
module frfm_rule_match (
   input  frfm_pkg::rule_entry_type entry,
   input  frfm_pkg::packet_type     pkt,
   output logic                     hit
);
   import frfm_pkg::*;

   logic [31:0] smask;
   logic [31:0] dmask;
   logic        dir_hit;
   logic        proto_hit;
   logic        ack_hit;
   logic        ports_hit;
   logic        sip_hit;
   logic        dip_hit;

   assign smask = prefix_mask(entry.src_prefix_len);
   assign dmask = prefix_mask(entry.dst_prefix_len);

   assign dir_hit   = (entry.direction == DIR_ANY) || (entry.direction == pkt.direction);
   assign proto_hit = (entry.protocol == PROTO_ANY) || (entry.protocol == pkt.protocol);
   // ack only counts for TCP, ports ignored for ICMP
   assign ack_hit   = (pkt.protocol != PROTO_TCP) || (entry.ack == ACK_ANY) ||
                      (entry.ack == pkt.ack);
   assign ports_hit = (pkt.protocol == PROTO_ICMP) ||
                      (port_hit(entry.sport, pkt.sport) &&
                       port_hit(entry.dport, pkt.dport));
   assign sip_hit   = (entry.src_ip == 32'd0) || ((pkt.src_ip & smask) == (entry.src_ip & smask));
   assign dip_hit   = (entry.dst_ip == 32'd0) || ((pkt.dst_ip & dmask) == (entry.dst_ip & dmask));

   assign hit = dir_hit && proto_hit && ack_hit && ports_hit && sip_hit && dip_hit;

endmodule

@@ tb/firewall_rule_first_match_test.sv @@
// ----------------------------------------------------------------------------
// firewall_rule_first_match_test
// Self-checking bench for the first-match rule table. A directed table covers
// rule checks, wildcards, prefix and port corner cases; then the table is
// filled and random rule writes and packet lookups run under several
// rule_count settings, checked against a local model, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module firewall_rule_first_match_test;
   import frfm_pkg::*;

   localparam logic [1:0] DIR_NONE   = 2'd0;
   localparam logic [1:0] DIR_IN     = 2'd1;
   localparam logic [1:0] DIR_OUT    = 2'd2;
   localparam logic [1:0] ACK_NONE   = 2'd0;
   localparam logic [1:0] ACK_NO     = 2'd1;
   localparam logic [1:0] ACK_YES    = 2'd2;
   localparam logic       ACT_DROP   = 1'b0;
   localparam logic       ACT_ACCEPT = 1'b1;

   // field order follows the request ports; 128 bits in total
   typedef struct packed {
      logic        kind;
      logic [5:0]  index;
      logic [1:0]  dir;
      logic [7:0]  proto;
      logic [31:0] sip;
      logic [31:0] dip;
      logic [5:0]  slen;
      logic [5:0]  dlen;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  ack;
      logic        act;
   } filter_req_t;

   typedef struct packed {
      status_type status;
      logic [6:0] number;
      logic       verdict;
   } filter_rsp_t;

   typedef struct packed {
      logic [1:0]  dir;
      logic [7:0]  proto;
      logic [31:0] sip;
      logic [31:0] dip;
      logic [31:0] smask;
      logic [31:0] dmask;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  ack;
      logic        act;
   } filter_rule_t;

   typedef struct {
      int          rule_count;   // -1: leave as is
      filter_req_t rq;
      bit          typed;
      filter_rsp_t want;
   } plan_row_t;

   localparam filter_rsp_t RSP_STORED   = '{ST_STORED, 7'd0, 1'b0};
   localparam filter_rsp_t RSP_REJECTED = '{ST_REJECTED, 7'd0, 1'b0};
   localparam filter_rsp_t RSP_NO_MATCH = '{ST_NO_MATCH, 7'd0, 1'b0};

   logic        clock;
   logic        reset              = 1'b1;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic        req_type           = 1'b0;
   logic [5:0]  req_rule_index     = '0;
   logic [1:0]  req_direction      = '0;
   logic [7:0]  req_protocol       = '0;
   logic [31:0] req_src_ip         = '0;
   logic [31:0] req_dst_ip         = '0;
   logic [5:0]  req_src_prefix_len = '0;
   logic [5:0]  req_dst_prefix_len = '0;
   logic [15:0] req_sport          = '0;
   logic [15:0] req_dport          = '0;
   logic [1:0]  req_ack            = '0;
   logic        req_rule_action    = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_rule_number;
   logic        rsp_verdict;
   logic        csr_wr_en          = 1'b0;
   logic [6:0]  csr_wr_data        = '0;

   filter_rule_t rule_mem [TABLE_DEPTH];
   logic [6:0]   model_count = '0;
   filter_rsp_t  pending_verdicts [$];
   plan_row_t    directed_plan [$];

   int mismatch_count = 0;
   int sent_count     = 0;
   int settings_count = 0;
   int n_stored       = 0;
   int n_rejected     = 0;
   int n_hit          = 0;
   int n_miss         = 0;
   int gap_pct        = 0;
   int stall_pct      = 0;
   int stall_left     = 0;

   firewall_rule_first_match i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_rule_index     (req_rule_index),
      .req_direction      (req_direction),
      .req_protocol       (req_protocol),
      .req_src_ip         (req_src_ip),
      .req_dst_ip         (req_dst_ip),
      .req_src_prefix_len (req_src_prefix_len),
      .req_dst_prefix_len (req_dst_prefix_len),
      .req_sport          (req_sport),
      .req_dport          (req_dport),
      .req_ack            (req_ack),
      .req_rule_action    (req_rule_action),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_rule_number    (rsp_rule_number),
      .rsp_verdict        (rsp_verdict),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(64'd10_000_000);
      $display("simulation timeout");
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------- local model of the rule table ----------------

   function automatic logic [31:0] cidr_mask(input logic [5:0] len);
      // shifting the full mask right by 32 leaves zero, so /32 is all ones
      return (len == 6'd0) ? 32'd0 : ~(32'hFFFF_FFFF >> len);
   endfunction

   function automatic bit port_matches(input logic [15:0] rp, input logic [15:0] pp);
      return (rp == 16'd0) || (rp == PORT_HIGH && pp >= PORT_HIGH) || (rp == pp);
   endfunction

   function automatic bit rule_acceptable(input filter_req_t rq);
      if (rq.dir == DIR_NONE || rq.ack == ACK_NONE) return 1'b0;
      if (!(rq.proto inside {PROTO_ICMP, PROTO_TCP, PROTO_UDP, PROTO_OTHER, PROTO_ANY}))
         return 1'b0;
      if (rq.slen > PREFIX_MAX || rq.dlen > PREFIX_MAX) return 1'b0;
      if (rq.sport > PORT_HIGH || rq.dport > PORT_HIGH) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit rule_covers(input filter_rule_t r, input filter_req_t p);
      if (r.dir != DIR_ANY && r.dir != p.dir) return 1'b0;
      if (r.proto != PROTO_ANY && r.proto != p.proto) return 1'b0;
      if (p.proto == PROTO_TCP && r.ack != ACK_ANY && r.ack != p.ack) return 1'b0;
      if (p.proto != PROTO_ICMP &&
          !(port_matches(r.sport, p.sport) && port_matches(r.dport, p.dport)))
         return 1'b0;
      if (r.dip != 32'd0 && ((p.dip ^ r.dip) & r.dmask) != 32'd0) return 1'b0;
      if (r.sip != 32'd0 && ((p.sip ^ r.sip) & r.smask) != 32'd0) return 1'b0;
      return 1'b1;
   endfunction

   // updates the model table on an accepted write, scans it on a lookup
   function automatic filter_rsp_t filter_verdict(input filter_req_t rq);
      filter_rule_t r;
      int           n;
      if (rq.kind == REQ_WRITE) begin
         if (!rule_acceptable(rq)) return RSP_REJECTED;
         r.dir   = rq.dir;
         r.proto = rq.proto;
         r.sip   = rq.sip;
         r.dip   = rq.dip;
         r.smask = cidr_mask(rq.slen);
         r.dmask = cidr_mask(rq.dlen);
         r.sport = rq.sport;
         r.dport = rq.dport;
         r.ack   = rq.ack;
         r.act   = rq.act;
         rule_mem[rq.index] = r;
         return RSP_STORED;
      end
      n = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
      for (int i = 0; i < n; i++) begin
         if (rule_covers(rule_mem[i], rq)) return '{ST_MATCH, 7'(i + 1), rule_mem[i].act};
      end
      return RSP_NO_MATCH;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic filter_req_t rq_of(
      input logic kind, input logic [5:0] idx, input logic [1:0] dir,
      input logic [7:0] proto, input logic [31:0] sip, input logic [5:0] slen,
      input logic [31:0] dip, input logic [5:0] dlen, input logic [15:0] sport,
      input logic [15:0] dport, input logic [1:0] ack, input logic act);
      filter_req_t rq;
      rq.kind  = kind;
      rq.index = idx;
      rq.dir   = dir;
      rq.proto = proto;
      rq.sip   = sip;
      rq.slen  = slen;
      rq.dip   = dip;
      rq.dlen  = dlen;
      rq.sport = sport;
      rq.dport = dport;
      rq.ack   = ack;
      rq.act   = act;
      return rq;
   endfunction

   function automatic filter_req_t noise_request(input logic kind);
      filter_req_t rq;
      rq = {$urandom, $urandom, $urandom, $urandom};
      rq.kind = kind;
      return rq;
   endfunction

   function automatic logic [7:0] pick_protocol();
      case ($urandom_range(0, 4))
         0:       return PROTO_ICMP;
         1:       return PROTO_TCP;
         2:       return PROTO_UDP;
         3:       return PROTO_OTHER;
         default: return PROTO_ANY;
      endcase
   endfunction

   function automatic logic [15:0] pick_rule_port();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return PORT_HIGH;
         default: return 16'($urandom_range(1, 1022));
      endcase
   endfunction

   // a packet port that the given rule port accepts
   function automatic logic [15:0] port_for_rule(input logic [15:0] rp);
      if (rp == 16'd0) return 16'($urandom_range(0, 65535));
      if (rp == PORT_HIGH) return 16'($urandom_range(1023, 65535));
      return rp;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 10;
         default: return 30;
      endcase
   endfunction

   function automatic filter_req_t random_rule(input logic [5:0] idx);
      filter_req_t rq;
      rq = noise_request(REQ_WRITE);
      rq.index = idx;
      rq.dir   = 2'($urandom_range(1, 3));
      rq.proto = pick_protocol();
      rq.sip   = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      rq.dip   = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      rq.slen  = 6'($urandom_range(0, 32));
      rq.dlen  = 6'($urandom_range(0, 32));
      rq.sport = pick_rule_port();
      rq.dport = pick_rule_port();
      rq.ack   = 2'($urandom_range(1, 3));
      return rq;
   endfunction

   function automatic filter_req_t broken_rule();
      filter_req_t rq;
      rq = random_rule(6'($urandom_range(0, 63)));
      case ($urandom_range(0, 7))
         0:       rq.dir   = DIR_NONE;
         1:       rq.proto = 8'($urandom_range(0, 255));
         2:       rq.ack   = ACK_NONE;
         3:       rq.slen  = 6'($urandom_range(33, 63));
         4:       rq.dlen  = 6'($urandom_range(33, 63));
         5:       rq.sport = 16'($urandom_range(1024, 65535));
         6:       rq.dport = 16'($urandom_range(1024, 65535));
         default: rq = noise_request(REQ_WRITE);
      endcase
      return rq;
   endfunction

   function automatic filter_req_t packet_for_rule(input filter_rule_t r);
      filter_req_t rq;
      rq = noise_request(REQ_MATCH);
      rq.dir   = (r.dir == DIR_ANY) ? 2'($urandom_range(1, 2)) : r.dir;
      rq.proto = (r.proto == PROTO_ANY) ? pick_protocol() : r.proto;
      rq.sip   = (r.sip & r.smask) | ($urandom & ~r.smask);
      rq.dip   = (r.dip & r.dmask) | ($urandom & ~r.dmask);
      rq.sport = port_for_rule(r.sport);
      rq.dport = port_for_rule(r.dport);
      rq.ack   = (r.ack == ACK_ANY) ? 2'($urandom_range(1, 2)) : r.ack;
      return rq;
   endfunction

   // ---------------- driving ----------------

   // called at a rising edge; returns at the edge where the request is taken
   task automatic issue_request(input filter_req_t rq, input bit typed,
                                input filter_rsp_t want);
      filter_rsp_t predicted;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= rq.kind;
      req_rule_index     <= rq.index;
      req_direction      <= rq.dir;
      req_protocol       <= rq.proto;
      req_src_ip         <= rq.sip;
      req_dst_ip         <= rq.dip;
      req_src_prefix_len <= rq.slen;
      req_dst_prefix_len <= rq.dlen;
      req_sport          <= rq.sport;
      req_dport          <= rq.dport;
      req_ack            <= rq.ack;
      req_rule_action    <= rq.act;
      do @(posedge clock); while (req_stall);
      predicted = filter_verdict(rq);
      pending_verdicts.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   // only while idle: drain all outstanding responses first
   task automatic set_rule_count(input logic [6:0] value);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_count = value;
      settings_count++;
   endtask

   // ---------------- response side ----------------

   always @(posedge clock) begin : response_check
      filter_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with no request outstanding, status %0d", rsp_status);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_rule_number !== want.number) begin
               $error("rule_number: expected %0d, got %0d", want.number, rsp_rule_number);
               mismatch_count++;
            end
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_verdict);
               mismatch_count++;
            end
            case (want.status)
               ST_STORED:   n_stored++;
               ST_REJECTED: n_rejected++;
               ST_MATCH:    n_hit++;
               default:     n_miss++;
            endcase
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 8);
      end
      rsp_stall <= (stall_left > 0);
   end

   // ---------------- test sequence ----------------

   initial begin : stimulus
      plan_row_t   row;
      filter_req_t rq;
      int          n_scan;
      int          pick;
      logic [6:0]  count_val;

      // lookups with count 0 scan nothing
      directed_plan.push_back('{0, rq_of(REQ_MATCH, 0, DIR_IN, PROTO_TCP, 32'h0A01_0203, 0,
         32'h0101_0101, 0, 1234, 80, ACK_YES, ACT_DROP), 1'b1, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 0, DIR_IN, PROTO_TCP, 32'h0A00_0000, 8,
         32'h0, 0, 0, 80, ACK_YES, ACT_ACCEPT), 1'b1, RSP_STORED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 1, DIR_OUT, PROTO_UDP, 32'h0, 0,
         32'hC0A8_0101, 32, PORT_HIGH, 53, ACK_NO, ACT_DROP), 1'b1, RSP_STORED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 2, DIR_ANY, PROTO_ICMP, 32'hFFFF_FFFF, 32,
         32'h0, 0, PORT_HIGH, PORT_HIGH, ACK_ANY, ACT_ACCEPT), 1'b1, RSP_STORED});
      // catch-all
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 3, DIR_ANY, PROTO_ANY, 32'h0, 0,
         32'h0, 0, 0, 0, ACK_ANY, ACT_DROP), 1'b1, RSP_STORED});
      // top entry, zero-length prefix on a nonzero address
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 63, DIR_IN, PROTO_OTHER, 32'hFFFF_FFFF, 0,
         32'h0102_0304, 32, 1, 1022, ACK_NO, ACT_ACCEPT), 1'b1, RSP_STORED});
      // each rule check on its own; entries 0..3 must survive
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 0, DIR_NONE, PROTO_TCP, 32'h0, 0,
         32'h0, 0, 0, 0, ACK_ANY, ACT_ACCEPT), 1'b1, RSP_REJECTED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 1, DIR_IN, 8'd2, 32'h0, 0,
         32'h0, 0, 0, 0, ACK_ANY, ACT_ACCEPT), 1'b1, RSP_REJECTED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 2, DIR_IN, PROTO_UDP, 32'h0, 0,
         32'h0, 0, 0, 0, ACK_NONE, ACT_ACCEPT), 1'b1, RSP_REJECTED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 3, DIR_IN, PROTO_UDP, 32'h0A00_0000, 33,
         32'h0, 0, 0, 0, ACK_ANY, ACT_ACCEPT), 1'b1, RSP_REJECTED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 63, DIR_IN, PROTO_UDP, 32'h0, 0,
         32'h0A00_0000, 63, 0, 0, ACK_ANY, ACT_ACCEPT), 1'b1, RSP_REJECTED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 0, DIR_OUT, PROTO_TCP, 32'h0, 0,
         32'h0, 0, 1024, 0, ACK_ANY, ACT_ACCEPT), 1'b1, RSP_REJECTED});
      directed_plan.push_back('{-1, rq_of(REQ_WRITE, 1, DIR_OUT, PROTO_TCP, 32'h0, 0,
         32'h0, 0, 0, 16'hFFFF, ACK_ANY, ACT_ACCEPT), 1'b1, RSP_REJECTED});
      // lookups over entries 0..3
      directed_plan.push_back('{4, rq_of(REQ_MATCH, 0, DIR_IN, PROTO_TCP, 32'h0AC8_0304, 0,
         32'h0808_0808, 0, 40000, 80, ACK_YES, ACT_DROP), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_MATCH, 0, DIR_IN, PROTO_TCP, 32'h0AC8_0304, 0,
         32'h0808_0808, 0, 40000, 80, ACK_NO, ACT_DROP), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_MATCH, 0, DIR_OUT, PROTO_UDP, 32'h0102_0304, 0,
         32'hC0A8_0101, 0, 5000, 53, ACK_NONE, ACT_DROP), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_MATCH, 0, DIR_OUT, PROTO_UDP, 32'h0102_0304, 0,
         32'hC0A8_0101, 0, 1022, 53, ACK_NONE, ACT_DROP), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_MATCH, 0, DIR_IN, PROTO_ICMP, 32'hFFFF_FFFF, 0,
         32'h0, 0, 0, 0, ACK_NO, ACT_DROP), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_MATCH, 0, DIR_OUT, PROTO_ICMP, 32'hFFFF_FFFE, 0,
         32'h0, 0, 7, 7, ACK_NO, ACT_DROP), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_MATCH, 63, DIR_ANY, 8'hFF, 32'hFFFF_FFFF, 63,
         32'hFFFF_FFFF, 63, 16'hFFFF, 16'hFFFF, ACK_ANY, ACT_ACCEPT), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{-1, rq_of(REQ_MATCH, 0, DIR_NONE, 8'h00, 32'h0, 0,
         32'h0, 0, 0, 0, ACK_NONE, ACT_DROP), 1'b0, RSP_NO_MATCH});
      directed_plan.push_back('{0, rq_of(REQ_MATCH, 0, DIR_OUT, PROTO_UDP, 32'h0102_0304, 0,
         32'hC0A8_0101, 0, 5000, 53, ACK_NO, ACT_DROP), 1'b1, RSP_NO_MATCH});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_rule_count(7'd0);
      gap_pct   = 10;
      stall_pct = 10;
      foreach (directed_plan[k]) begin
         row = directed_plan[k];
         if (row.rule_count >= 0 && row.rule_count != int'(model_count))
            set_rule_count(7'(row.rule_count));
         issue_request(row.rq, row.typed, row.want);
      end

      // every entry written before any scan can reach it
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         issue_request(random_rule(6'(k)), 1'b0, RSP_STORED);
      end

      for (int phase = 0; phase < 16; phase++) begin
         case (phase)
            0:       count_val = 7'd64;
            1:       count_val = 7'd1;
            2:       count_val = 7'd127;
            3:       count_val = 7'd65;
            default: count_val = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 8))
                                                            : 7'($urandom_range(9, 64));
         endcase
         set_rule_count(count_val);
         if (phase == 15) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = pick_idle_pct();
            stall_pct = pick_idle_pct();
         end
         n_scan = (count_val > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_val);
         repeat (105) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
               rq = random_rule(6'($urandom_range(0, 63)));
            end else if (pick == 4) begin
               rq = broken_rule();
            end else if (n_scan == 0 || pick < 8) begin
               rq = noise_request(REQ_MATCH);
            end else begin
               rq = packet_for_rule(rule_mem[$urandom_range(0, n_scan - 1)]);
               // near misses: one header bit off
               if (pick < 12) begin
                  case ($urandom_range(0, 6))
                     0:       rq.dir   ^= 2'd1 << $urandom_range(0, 1);
                     1:       rq.proto ^= 8'd1 << $urandom_range(0, 7);
                     2:       rq.sip   ^= 32'd1 << $urandom_range(0, 31);
                     3:       rq.dip   ^= 32'd1 << $urandom_range(0, 31);
                     4:       rq.sport ^= 16'd1 << $urandom_range(0, 15);
                     5:       rq.dport ^= 16'd1 << $urandom_range(0, 15);
                     default: rq.ack   ^= 2'd1 << $urandom_range(0, 1);
                  endcase
               end
            end
            issue_request(rq, 1'b0, RSP_STORED);
         end
      end

      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("ran %0d requests: %0d rules stored, %0d rejected, %0d lookups hit, %0d missed",
               sent_count, n_stored, n_rejected, n_hit, n_miss);
      $display("rule_count set %0d times, from 0 through 127", settings_count);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/frfm_pkg.sv
rtl/frfm_rule_ram.sv
rtl/frfm_rule_check.sv
rtl/frfm_rule_match.sv
rtl/firewall_rule_first_match.sv
tb/firewall_rule_first_match_test.sv
